// ===== sv/unsigned_divider_64_macros.svh =====
// ---------------------------------------------------------------------------
// unsigned_divider_64 assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef UNSIGNED_DIVIDER_64_MACROS_SVH
`define UNSIGNED_DIVIDER_64_MACROS_SVH

// same-cycle implication
`define UD64_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unsigned_divider_64: check failed");

// next-cycle implication
`define UD64_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unsigned_divider_64: check failed");

`endif

// ===== sv/ud64_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ud64_pkg
// Widths and the per-stage word type of the pipelined divider.
// ---------------------------------------------------------------------------
package ud64_pkg;

    localparam int DW      = 64;         // operand width
    localparam int STAGES  = DW;         // one quotient bit per stage
    localparam int TDATA_W = ((2 * DW + 7) / 8) * 8;

    typedef struct packed {
        logic          valid;
        logic [DW-1:0] part;   // partial remainder
        logic [DW-1:0] nq;     // dividend bits still to shift in above, quotient below
        logic [DW-1:0] den;
    } stage_t;

endpackage

// ===== sv/ud64_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ud64_stage
// One restoring step: shift in a dividend bit, trial subtract, register.
// ---------------------------------------------------------------------------
module ud64_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  ud64_pkg::stage_t din,
    output ud64_pkg::stage_t dout
);

    logic [ud64_pkg::DW-1:0] part_sh;
    logic [ud64_pkg::DW-1:0] diff;
    logic                    ge;
    ud64_pkg::stage_t        dout_next;
    ud64_pkg::stage_t        dout_reg;

    always_comb
    begin
        // top bit of the shifted remainder drops out of the 64-bit datapath
        part_sh         = {din.part[ud64_pkg::DW-2:0], din.nq[ud64_pkg::DW-1]};
        diff            = part_sh - din.den;
        ge              = (part_sh >= din.den);
        dout_next.valid = din.valid;
        dout_next.part  = ge ? diff : part_sh;
        dout_next.nq    = {din.nq[ud64_pkg::DW-2:0], ge};
        dout_next.den   = din.den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ===== sv/unsigned_divider_64.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unsigned_divider_64
// Pipelined restoring divider: 64-bit quotient and remainder per word.
// ---------------------------------------------------------------------------
//
//  channel   dir   tdata (low bit up)            notes
//  s_*       in    dividend[63:0], divisor       one operand pair per word
//  m_*       out   quotient[63:0], remainder     one result word per input
//
//  Throughput: one word per cycle while s_tready is high. A word passes through
//  64 step stages, one trial subtract each, then the output register to m_tvalid.
//  Divide by zero gives quotient all ones and remainder equal to the dividend.
//  rst_n (async, active low) clears the stage registers and the output and skid valid bits; the pipeline starts empty.
//  Stall: when m_tready is low the output register holds and a skid register
//  catches the next result; s_tready drops and the whole pipe freezes until
//  the skid word is passed on. Nothing is lost or repeated.
//
module unsigned_divider_64
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ud64_pkg::TDATA_W-1:0]   s_tdata,   // dividend, divisor

    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ud64_pkg::TDATA_W-1:0]   m_tdata    // quotient, remainder
);

    localparam int DW = ud64_pkg::DW;

    ud64_pkg::stage_t stg [ud64_pkg::STAGES+1];
    logic             en;

    logic                out_valid_reg, out_valid_next;
    logic [2*DW-1:0]     out_data_reg,  out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [2*DW-1:0]     skid_data_reg,  skid_data_next;
    logic [2*DW-1:0]     tail_data;

    // pipe advances whenever the skid register is free
    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    // stage 0 input: partial remainder starts at zero
    always_comb
    begin
        stg[0].valid = s_tvalid;
        stg[0].part  = '0;
        stg[0].nq    = s_tdata[DW-1:0];
        stg[0].den   = s_tdata[2*DW-1:DW];
    end

    for (genvar k = 0; k < ud64_pkg::STAGES; k++)
    begin : g_step
        ud64_stage u_stage
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (stg[k]),
            .dout  (stg[k+1])
        );
    end

    // after the last step nq is the quotient, part the remainder
    assign tail_data = {stg[ud64_pkg::STAGES].part, stg[ud64_pkg::STAGES].nq};

    // output register with skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (skid_valid_reg)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (stg[ud64_pkg::STAGES].valid)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_valid_next = 1'b1;
                out_data_next  = tail_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = tail_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ud64_pkg::TDATA_W'(out_data_reg);

endmodule

// ===== sv/ud64_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ud64_checker
// Port-level checks on stall and skid behavior of the divider.
// ---------------------------------------------------------------------------
`include "unsigned_divider_64_macros.svh"

module ud64_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [ud64_pkg::TDATA_W-1:0] s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ud64_pkg::TDATA_W-1:0] m_tdata
);

    logic s_unused;
    assign s_unused = s_tvalid ^ (^s_tdata);

    // stalled result word holds
    `UD64_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // input only blocks behind a waiting result
    `UD64_IMPLY(a_block_needs_out, !s_tready, m_tvalid)
    // input blocks only after an output stall
    `UD64_IMPLY(a_block_cause, $fell(s_tready), $past(m_tvalid && !m_tready))
    // blocked input stays blocked while the sink stalls
    `UD64_NEXT(a_block_stays, !s_tready && !m_tready, !s_tready)

endmodule

bind unsigned_divider_64 ud64_checker u_ud64_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
